>>> design/hne_pkg.sv
// Shared types and constants of the heightmap normal engine.
// No dependencies; the controller, datapath, top level and testbench import this package.
`timescale 1ns / 1ps
`default_nettype none
package hne_pkg;

    localparam int GRID_SIDE = 64;
    localparam int COORD_W   = 6;
    localparam int SAMPLE_W  = 16;
    localparam int ADDR_W    = $clog2(GRID_SIDE * GRID_SIDE);
    localparam int DEPTH     = GRID_SIDE * GRID_SIDE;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // |dx| * W * mh fits 16 + 6 + 16 bits
    localparam int MAG_W  = 38;
    localparam int HI_W   = MAG_W - 32;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int PW     = 112;
    localparam int Q_W    = 15;
    localparam int CNT_W  = 4;

    localparam int NX_W = 16;
    localparam int NY_W = 15;
    localparam int NZ_W = 16;

    localparam logic [PW-1:0] UNIT_SQ = PW'(32767 * 32767);
    localparam logic [PW-1:0] T_Y     = UNIT_SQ << 48;
    localparam logic [SUM_W-1:0] B_SQ = SUM_W'(1) << 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_LENGTH = 2'd1,
        CFG_MAX_HEIGHT  = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE, OP_ACCEPT, OP_READ, OP_DIFF, OP_SCALE1, OP_SCALE2,
        OP_SQ, OP_SUM, OP_INIT, OP_ITER, OP_STORE, OP_PUBLISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op            op;
        logic [CNT_W-1:0]  cnt;
        logic [1:0]        comp;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

>>> design/hne_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module hne_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> design/hne_ctrl.sv
// Controller of the heightmap normal engine: sequences reads, squaring,
// the bit-serial normalization and result hand-off. Uses hne_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hne_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_query,
    output logic                 o_in_ready,
    input  wire hne_pkg::t_status i_status,
    output hne_pkg::t_cmd        o_cmd
);
    import hne_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_READ   = 11'b00000000010,
        S_DIFF   = 11'b00000000100,
        S_SCALE1 = 11'b00000001000,
        S_SCALE2 = 11'b00000010000,
        S_SQ     = 11'b00000100000,
        S_SUM    = 11'b00001000000,
        S_INIT   = 11'b00010000000,
        S_ITER   = 11'b00100000000,
        S_STORE  = 11'b01000000000,
        S_PUB    = 11'b10000000000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_comp, n_comp;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_comp   = r_comp;
        o_cmd.op   = OP_NONE;
        o_cmd.cnt  = r_cnt;
        o_cmd.comp = r_comp;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    if (i_in_query) begin
                        n_state = S_READ;
                        n_cnt   = '0;
                    end
                end
            end
            S_READ: begin
                o_cmd.op = OP_READ;
                if (r_cnt == '0 && i_status.bad) begin
                    n_state = S_PUB;
                end else if (r_cnt == CNT_W'(4)) begin
                    n_state = S_DIFF;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = S_SCALE1;
            end
            S_SCALE1: begin
                o_cmd.op = OP_SCALE1;
                n_state  = S_SCALE2;
            end
            S_SCALE2: begin
                o_cmd.op = OP_SCALE2;
                n_state  = S_SQ;
                n_cnt    = '0;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                if (r_cnt == CNT_W'(7)) begin
                    n_state = S_SUM;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                n_state  = S_INIT;
                n_comp   = '0;
            end
            S_INIT: begin
                o_cmd.op = OP_INIT;
                n_state  = S_ITER;
                n_cnt    = CNT_W'(Q_W - 1);
            end
            S_ITER: begin
                o_cmd.op = OP_ITER;
                if (r_cnt == '0) begin
                    n_state = S_STORE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_STORE: begin
                o_cmd.op = OP_STORE;
                if (r_comp == 2'd2) begin
                    n_state = S_PUB;
                end else begin
                    n_comp  = r_comp + 1'b1;
                    n_state = S_INIT;
                end
            end
            S_PUB: begin
                if (!i_status.out_busy) begin
                    o_cmd.op = OP_PUBLISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_comp  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_comp  <= n_comp;
        end
    end
endmodule
`default_nettype wire

>>> design/hne_dp.sv
// Datapath of the heightmap normal engine: config registers, sample RAM,
// difference and scale, squaring by partial products, bit-serial
// normalization, output register. Uses hne_pkg and hne_ram.
`timescale 1ns / 1ps
`default_nettype none
module hne_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [hne_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [hne_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  wire logic                        i_in_query,
    input  wire logic [hne_pkg::COORD_W-1:0] i_col,
    input  wire logic [hne_pkg::COORD_W-1:0] i_row,
    input  wire logic [hne_pkg::SAMPLE_W-1:0] i_sample,
    input  wire hne_pkg::t_cmd               i_cmd,
    output hne_pkg::t_status                 o_status,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic [hne_pkg::NX_W-1:0]         o_norm_x,
    output logic [hne_pkg::NY_W-1:0]         o_norm_y,
    output logic [hne_pkg::NZ_W-1:0]         o_norm_z,
    output logic                             o_bad
);
    import hne_pkg::*;

    logic [COORD_W-1:0]  r_gw, r_gl;
    logic [15:0]         r_mh;
    logic                r_bad;
    logic [COORD_W-1:0]  r_x, r_z;
    logic                r_rv;
    logic [SAMPLE_W-1:0] r_smp [4];
    logic                r_negx, r_negz;
    logic [SAMPLE_W-1:0] r_adx, r_adz;
    logic [MAG_W-1:0]    r_ma, r_mc;
    logic [63:0]         r_pp;
    logic [SQ_W-1:0]     r_acc, r_ma2, r_mc2;
    logic [SUM_W-1:0]    r_s;
    logic [PW-1:0]       r_t, r_p, r_qs;
    logic [Q_W-1:0]      r_q;
    logic [NX_W-1:0]     r_nx;
    logic [NY_W-1:0]     r_ny;
    logic [NZ_W-1:0]     r_nz;
    logic                r_ovalid;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= COORD_W'(63);
            r_gl <= COORD_W'(63);
            r_mh <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_GRID_WIDTH:  r_gw <= i_cfg_wdata[COORD_W-1:0];
                CFG_GRID_LENGTH: r_gl <= i_cfg_wdata[COORD_W-1:0];
                CFG_MAX_HEIGHT:  r_mh <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // query coordinate, clamped one step inward at the edges
    logic [COORD_W-1:0] x0, z0, xc, zc;
    always_comb begin
        x0 = (i_col == '0) ? COORD_W'(1) : i_col;
        z0 = (i_row == '0) ? COORD_W'(1) : i_row;
        xc = (x0 == r_gw) ? x0 - 1'b1 : x0;
        zc = (z0 == r_gl) ? z0 - 1'b1 : z0;
    end

    // neighbour address for the read in flight
    logic [COORD_W:0] nc, nr;
    logic             nvalid;
    always_comb begin
        nc = {1'b0, r_x};
        nr = {1'b0, r_z};
        case (i_cmd.cnt[1:0])
            2'd0:    nc = {1'b0, r_x} - 1'b1;
            2'd1:    nc = {1'b0, r_x} + 1'b1;
            2'd2:    nr = {1'b0, r_z} - 1'b1;
            default: nr = {1'b0, r_z} + 1'b1;
        endcase
        nvalid = !nc[COORD_W] && !nr[COORD_W]
               && (int'(nc) < GRID_SIDE) && (int'(nr) < GRID_SIDE);
    end

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [SAMPLE_W-1:0] ram_rdata;
    always_comb begin
        ram_we   = (i_cmd.op == OP_ACCEPT) && !i_in_query
                 && (int'(i_col) < GRID_SIDE) && (int'(i_row) < GRID_SIDE);
        if (i_cmd.op == OP_ACCEPT) begin
            ram_addr = ADDR_W'(int'(i_row) * GRID_SIDE + int'(i_col));
        end else begin
            ram_addr = ADDR_W'(int'(nr[COORD_W-1:0]) * GRID_SIDE
                               + int'(nc[COORD_W-1:0]));
        end
    end

    hne_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_sample),
        .o_rdata (ram_rdata)
    );

    // difference and bit-serial helpers
    logic [SAMPLE_W:0] dx, dz;
    logic [MAG_W-1:0]  sq_op;
    logic [31:0]       sq_lo;
    logic [HI_W-1:0]   sq_hi;
    logic [PW-1:0]     s_ext, cand, t_src;
    logic [3:0]        k;
    always_comb begin
        dx    = {1'b0, r_smp[0]} - {1'b0, r_smp[1]};
        dz    = {1'b0, r_smp[2]} - {1'b0, r_smp[3]};
        sq_op = i_cmd.cnt[2] ? r_mc : r_ma;
        sq_lo = sq_op[31:0];
        sq_hi = sq_op[MAG_W-1:32];
        k     = i_cmd.cnt;
        s_ext = PW'(r_s);
        cand  = r_p + (((r_qs << 1) + (s_ext << k)) << k);
        t_src = (i_cmd.comp == 2'd0) ? PW'(r_ma2) : PW'(r_mc2);
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_bad <= (i_col > r_gw) || (i_row > r_gl);
                r_x   <= xc;
                r_z   <= zc;
            end
            OP_READ: begin
                r_rv <= nvalid;
                if (i_cmd.cnt != '0) begin
                    r_smp[i_cmd.cnt[1:0] - 2'd1] <= r_rv ? ram_rdata : '0;
                end
            end
            OP_DIFF: begin
                r_negx <= dx[SAMPLE_W];
                r_negz <= dz[SAMPLE_W];
                r_adx  <= dx[SAMPLE_W] ? SAMPLE_W'(-dx) : dx[SAMPLE_W-1:0];
                r_adz  <= dz[SAMPLE_W] ? SAMPLE_W'(-dz) : dz[SAMPLE_W-1:0];
            end
            OP_SCALE1: begin
                r_ma <= MAG_W'(r_adx) * MAG_W'(r_gw);
                r_mc <= MAG_W'(r_adz) * MAG_W'(r_gl);
            end
            OP_SCALE2: begin
                r_ma <= r_ma * MAG_W'(r_mh);
                r_mc <= r_mc * MAG_W'(r_mh);
            end
            OP_SQ: begin
                case (i_cmd.cnt[1:0])
                    2'd0: r_pp <= 64'(sq_lo) * 64'(sq_lo);
                    2'd1: begin
                        r_acc <= SQ_W'(r_pp);
                        r_pp  <= 64'(sq_lo) * 64'(sq_hi);
                    end
                    2'd2: begin
                        r_acc <= r_acc + (SQ_W'(r_pp) << 33);
                        r_pp  <= 64'(sq_hi) * 64'(sq_hi);
                    end
                    default: begin
                        if (i_cmd.cnt[2]) begin
                            r_mc2 <= r_acc + (SQ_W'(r_pp) << 64);
                        end else begin
                            r_ma2 <= r_acc + (SQ_W'(r_pp) << 64);
                        end
                    end
                endcase
            end
            OP_SUM: r_s <= SUM_W'(r_ma2) + SUM_W'(r_mc2) + B_SQ;
            OP_INIT: begin
                // target (32767 * mag)^2, with 32767^2 = 2^30 - 2^16 + 1
                r_t  <= (i_cmd.comp == 2'd1) ? T_Y
                      : (t_src << 30) - (t_src << 16) + t_src;
                r_p  <= '0;
                r_qs <= '0;
                r_q  <= '0;
            end
            OP_ITER: begin
                if (cand <= r_t) begin
                    r_p  <= cand;
                    r_qs <= r_qs + (s_ext << k);
                    r_q  <= r_q | (Q_W'(1) << k);
                end
            end
            OP_STORE: begin
                case (i_cmd.comp)
                    2'd0:    r_nx <= r_negx ? NX_W'(0) - NX_W'(r_q) : NX_W'(r_q);
                    2'd1:    r_ny <= r_q;
                    default: r_nz <= r_negz ? NZ_W'(0) - NZ_W'(r_q) : NZ_W'(r_q);
                endcase
            end
            OP_PUBLISH: begin
                o_norm_x <= r_bad ? '0 : r_nx;
                o_norm_y <= r_bad ? '0 : r_ny;
                o_norm_z <= r_bad ? '0 : r_nz;
                o_bad    <= r_bad;
            end
            default: ;
        endcase
    end

    // output register: a new result may load in the cycle the old one drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_PUBLISH) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_status.bad      = r_bad;
    assign o_status.out_busy = r_ovalid && !i_out_ready;
endmodule
`default_nettype wire

>>> design/heightmap_normal_engine.sv
// Top level of the heightmap normal engine: stream ports, config port,
// and the controller/datapath pair. Uses hne_pkg, hne_ctrl, hne_dp.
`timescale 1ns / 1ps
`default_nettype none
// A load beat (tuser 0) writes one 16-bit height sample at (col, row)
// and gives no result. A query beat (tuser 1) gives one result
// beat: the unit normal at the vertex from central differences of its
// four neighbours, edge vertices moved one step inward, each component
// scaled by 32767 and truncated; col > grid_width or row > grid_length
// gives bad_vertex with a zero normal. A query runs four reads on the
// single sample RAM port, two squarings of three partial products each,
// and three 15-step bit-serial normalizations. Query a vertex only
// after its neighbours are loaded; the store has no reset. Write config
// only while idle.
module heightmap_normal_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [hne_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [hne_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // col[5:0], row[11:6], sample[27:12]
    input  wire logic        s_axis_tuser,   // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // norm_x[15:0], norm_y[30:16], norm_z[46:31]
    output logic             m_axis_tuser    // bad_vertex
);
    import hne_pkg::*;

    t_cmd             cmd;
    t_status          status;
    logic [NX_W-1:0]  norm_x;
    logic [NY_W-1:0]  norm_y;
    logic [NZ_W-1:0]  norm_z;

    hne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_query (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    hne_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_query  (s_axis_tuser),
        .i_col       (s_axis_tdata[5:0]),
        .i_row       (s_axis_tdata[11:6]),
        .i_sample    (s_axis_tdata[27:12]),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_norm_x    (norm_x),
        .o_norm_y    (norm_y),
        .o_norm_z    (norm_z),
        .o_bad       (m_axis_tuser)
    );

    // pack result fields low to high, pad to whole bytes
    assign m_axis_tdata = {1'b0, norm_z, norm_y, norm_x};
endmodule
`default_nettype wire

>>> dv/heightmap_normal_engine_tb.sv
// Self-checking testbench for heightmap_normal_engine: directed table, then random
// loads and normal queries over several grid settings. Depends on hne_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none
module heightmap_normal_engine_tb;
    import hne_pkg::*;

    // One normal result as carried on the master stream
    typedef struct packed {
        logic [15:0] nx;
        logic [14:0] ny;
        logic [15:0] nz;
        logic        bad;
    } normal_t;

    // Row of the directed stimulus table; typed rows carry their own answer
    typedef struct {
        bit          is_query;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [15:0] smp;
        bit          typed;
        normal_t     answer;
    } vec_t;

    localparam normal_t FLAT_NORMAL = '{16'd0, 15'd32767, 16'd0, 1'b0};
    localparam normal_t BAD_NORMAL  = '{16'd0, 15'd0, 16'd0, 1'b1};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // col[5:0], row[11:6], sample[27:12]
    logic        s_axis_tuser = 1'b0; // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // norm_x[15:0], norm_y[30:16], norm_z[46:31]
    logic        m_axis_tuser;        // bad_vertex

    heightmap_normal_engine u_top (.*);

    always #6 i_clk = ~i_clk;

    // Shadow of the sample store and the grid registers
    logic [15:0] height_mem [0:4095];
    bit          height_known [0:4095];
    logic [5:0]  grid_w = 6'd63;
    logic [5:0]  grid_l = 6'd63;
    logic [15:0] height_scale = 16'd256;

    normal_t normals_due[$];
    vec_t    table_rows[$];
    int      fail_count = 0;
    int      loads_sent = 0;
    int      queries_sent = 0;
    int      normals_seen = 0;
    int      bad_seen = 0;
    bit      steady = 1'b0;   // no idling on either side

    function automatic logic [15:0] sample_at(int c, int r);
        if (c < 0 || r < 0 || c >= GRID_SIDE || r >= GRID_SIDE) return 16'd0;
        return height_mem[r * GRID_SIDE + c];
    endfunction

    // Move an edge vertex one step inward
    function automatic void clamp_vertex(input logic [5:0] col, row, output int x, z);
        x = col;
        z = row;
        if (x == 0) x = 1;
        if (z == 0) z = 1;
        if (x == grid_w) x--;
        if (z == grid_l) z--;
    endfunction

    // Largest q <= 32767 with q*q*sum <= (32767*mag)^2
    function automatic logic [14:0] unit_scale(logic [63:0] mag, logic [127:0] sum);
        logic [127:0] target;
        logic [127:0] lhs;
        logic [15:0]  t;
        logic [14:0]  q;
        target = (128'(mag) * 128'd32767) * (128'(mag) * 128'd32767);
        q = '0;
        for (int b = 14; b >= 0; b--) begin
            t = {1'b0, q} | (16'd1 << b);
            lhs = 128'(t) * 128'(t) * sum;
            if (lhs <= target) q = t[14:0];
        end
        return q;
    endfunction

    function automatic normal_t predict_normal(logic [5:0] col, logic [5:0] row);
        normal_t      n;
        int           x, z;
        longint       dx, dz;
        logic [63:0]  ma, mc;
        logic [127:0] sum;
        logic [14:0]  q;
        if (col > grid_w || row > grid_l) return BAD_NORMAL;
        clamp_vertex(col, row, x, z);
        dx = longint'(sample_at(x - 1, z)) - longint'(sample_at(x + 1, z));
        dz = longint'(sample_at(x, z - 1)) - longint'(sample_at(x, z + 1));
        ma = (dx < 0) ? -dx : dx;
        mc = (dz < 0) ? -dz : dz;
        ma = ma * 64'(grid_w) * 64'(height_scale);
        mc = mc * 64'(grid_l) * 64'(height_scale);
        sum = 128'(ma) * 128'(ma) + 128'(mc) * 128'(mc) + (128'd1 << 48);
        q = unit_scale(ma, sum);
        n.nx = (dx < 0) ? 16'd0 - 16'(q) : 16'(q);
        n.ny = unit_scale(64'd1 << 24, sum);
        q = unit_scale(mc, sum);
        n.nz = (dz < 0) ? 16'd0 - 16'(q) : 16'(q);
        n.bad = 1'b0;
        return n;
    endfunction

    // Drive one beat, hold it until taken, then update the shadow or queue the answer
    task automatic send_beat(bit is_query, logic [5:0] col, logic [5:0] row,
                             logic [15:0] smp, bit typed, normal_t answer);
        if (!steady && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, smp, row, col};
        s_axis_tuser  <= is_query;
        do @(posedge i_clk); while (!s_axis_tready);
        if (is_query) begin
            normals_due = {normals_due, (typed ? answer : predict_normal(col, row))};
            queries_sent++;
        end else begin
            height_mem[{row, col}]   = smp;
            height_known[{row, col}] = 1'b1;
            loads_sent++;
        end
    endtask

    task automatic load_beat(logic [5:0] col, logic [5:0] row, logic [15:0] smp);
        send_beat(1'b0, col, row, smp, 1'b0, BAD_NORMAL);
    endtask

    // Load any neighbour a query would read that the store has not seen yet
    task automatic fill_neighbours(logic [5:0] col, logic [5:0] row);
        int x, z;
        int nc [4];
        int nr [4];
        if (col > grid_w || row > grid_l) return;
        clamp_vertex(col, row, x, z);
        nc = '{x - 1, x + 1, x, x};
        nr = '{z, z, z - 1, z + 1};
        for (int k = 0; k < 4; k++) begin
            if (nc[k] >= 0 && nr[k] >= 0 && nc[k] < GRID_SIDE && nr[k] < GRID_SIDE &&
                !height_known[nr[k] * GRID_SIDE + nc[k]])
                load_beat(6'(nc[k]), 6'(nr[k]), 16'($urandom));
        end
    endtask

    // Drain results, then allow for a load still in flight before touching registers
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (normals_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic add_row(bit is_query, int col, int row, int smp, bit typed, normal_t answer);
        vec_t v;
        v.is_query = is_query;
        v.col      = 6'(col);
        v.row      = 6'(row);
        v.smp      = 16'(smp);
        v.typed    = typed;
        v.answer   = answer;
        table_rows = {table_rows, v};
    endtask

    // Receiver: random stall bursts until the steady stretch
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (steady) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 13);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each taken result beat against the oldest pending normal
    always @(posedge i_clk) begin
        normal_t want;
        normal_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[15:0], m_axis_tdata[30:16], m_axis_tdata[46:31], m_axis_tuser};
            normals_seen++;
            if (got.bad) bad_seen++;
            if (normals_due.size() == 0) begin
                $display("%0t: result beat with none pending: %h", $time, got);
                fail_count++;
            end else begin
                want = normals_due.pop_front();
                if (got.nx !== want.nx) begin
                    $display("%0t: norm_x expected %0d got %0d", $time,
                             $signed(want.nx), $signed(got.nx));
                    fail_count++;
                end
                if (got.ny !== want.ny) begin
                    $display("%0t: norm_y expected %0d got %0d", $time, want.ny, got.ny);
                    fail_count++;
                end
                if (got.nz !== want.nz) begin
                    $display("%0t: norm_z expected %0d got %0d", $time,
                             $signed(want.nz), $signed(got.nz));
                    fail_count++;
                end
                if (got.bad !== want.bad) begin
                    $display("%0t: bad_vertex expected %0b got %0b", $time, want.bad, got.bad);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        logic [15:0] setting [6][3];
        logic [5:0]  col, row;
        logic [15:0] smp;
        for (int i = 0; i < DEPTH; i++) height_known[i] = 1'b0;

        // Flat 3x3 patch in the corner, then ridges in each direction
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) add_row(0, c, r, 0, 0, BAD_NORMAL);
        add_row(0, 3, 2, 0, 0, BAD_NORMAL);
        add_row(0, 2, 3, 0, 0, BAD_NORMAL);
        add_row(1, 0, 0, 0, 1, FLAT_NORMAL);       // corner clamps inward
        add_row(1, 1, 1, 16'hFFFF, 1, FLAT_NORMAL); // sample ignored on a query
        add_row(1, 2, 2, 0, 1, FLAT_NORMAL);
        add_row(0, 0, 1, 65535, 0, BAD_NORMAL);
        add_row(1, 1, 1, 0, 0, BAD_NORMAL);         // steepest positive x slope
        add_row(0, 0, 1, 0, 0, BAD_NORMAL);
        add_row(0, 2, 1, 65535, 0, BAD_NORMAL);
        add_row(1, 1, 1, 0, 0, BAD_NORMAL);         // negative x slope
        add_row(0, 1, 0, 65535, 0, BAD_NORMAL);
        add_row(1, 0, 1, 0, 0, BAD_NORMAL);         // both slopes at once
        add_row(0, 1, 2, 65535, 0, BAD_NORMAL);
        add_row(1, 1, 1, 0, 0, BAD_NORMAL);
        // Far corner of the grid
        add_row(0, 61, 62, 0, 0, BAD_NORMAL);
        add_row(0, 63, 62, 65535, 0, BAD_NORMAL);
        add_row(0, 62, 61, 65535, 0, BAD_NORMAL);
        add_row(0, 62, 63, 0, 0, BAD_NORMAL);
        add_row(1, 63, 63, 0, 0, BAD_NORMAL);
        add_row(1, 62, 62, 0, 0, BAD_NORMAL);

        // Grid settings per phase: width, length, height scale
        setting = '{'{16'd63, 16'd63, 16'd256},
                    '{16'd2, 16'd2, 16'd0},
                    '{16'd63, 16'd63, 16'd65535},
                    '{16'd2, 16'd63, 16'd1},
                    '{16'd63, 16'd2, 16'd256},
                    '{16'(0), 16'(0), 16'(0)}};
        setting[5][0] = 16'($urandom_range(2, 63));
        setting[5][1] = 16'($urandom_range(2, 63));
        setting[5][2] = 16'($urandom);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i])
            send_beat(table_rows[i].is_query, table_rows[i].col, table_rows[i].row,
                      table_rows[i].smp, table_rows[i].typed, table_rows[i].answer);

        for (int ph = 1; ph < 6; ph++) begin
            wait_idle();
            grid_w       = setting[ph][0][5:0];
            grid_l       = setting[ph][1][5:0];
            height_scale = setting[ph][2];
            write_reg(CFG_GRID_WIDTH, setting[ph][0]);
            write_reg(CFG_GRID_LENGTH, setting[ph][1]);
            write_reg(CFG_MAX_HEIGHT, setting[ph][2]);
            if (ph == 5) steady = 1'b1;
            // Just past the grid on each axis, where the grid allows it
            if (grid_w < 63) send_beat(1'b1, grid_w + 6'd1, 6'd0, 16'd0, 1'b1, BAD_NORMAL);
            if (grid_l < 63) send_beat(1'b1, 6'd0, grid_l + 6'd1, 16'd0, 1'b1, BAD_NORMAL);

            for (int n = 0; n < 60; n++) begin
                col = 6'($urandom);
                row = 6'($urandom);
                case ($urandom_range(0, 3))
                    0: smp = 16'hFFFF;
                    1: smp = 16'd0;
                    default: smp = 16'($urandom);
                endcase
                if ($urandom_range(0, 9) < 4) begin
                    load_beat(col, row, smp);
                end else begin
                    // Mostly vertices inside the grid, some anywhere
                    if ($urandom_range(0, 6) != 0) begin
                        col = 6'($urandom_range(0, grid_w));
                        row = 6'($urandom_range(0, grid_l));
                    end
                    fill_neighbours(col, row);
                    send_beat(1'b1, col, row, 16'($urandom), 1'b0, BAD_NORMAL);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (normals_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Ran %0d load beats and %0d query beats over 6 grid settings,",
                 loads_sent, queries_sent);
        $display("checking %0d normals, %0d of them off-grid.", normals_seen, bad_seen);
        if (fail_count == 0) begin
            $display("heightmap_normal_engine: match");
        end else begin
            $display("heightmap_normal_engine: mismatch");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run
    initial begin
        #(40_000_000);
        $display("%0t: timeout with %0d normals pending", $time, normals_due.size());
        $display("heightmap_normal_engine: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
